### sv/apq_pkg.sv
// Shared types, codes and helpers for the unsorted-array priority queue.
package apq_pkg;

    localparam int VAL_W = 32;
    localparam int OCC_W = 4;

    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_DELETE = 1'b1;

    typedef logic [1:0] t_status;
    localparam t_status ST_DONE  = 2'd0;
    localparam t_status ST_FULL  = 2'd1;
    localparam t_status ST_EMPTY = 2'd2;

    typedef struct packed {
        logic                    func;
        logic signed [VAL_W-1:0] value;
    } t_in_word;

    typedef struct packed {
        t_status                 status;
        logic signed [VAL_W-1:0] removed_value;
        logic [OCC_W-1:0]        occupancy;
    } t_out_word;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } t_mem_ctl;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_RESP
    } t_state;

    // Occupancy is the entry count masked to the field width.
    function automatic logic [OCC_W-1:0] f_occ(input logic [31:0] c);
        return c[OCC_W-1:0];
    endfunction

endpackage

### sv/apq_cmp.sv
// Shared signed less-than unit used by the minimum scan.
module apq_cmp (
    input  logic signed [apq_pkg::VAL_W-1:0] i_a,
    input  logic signed [apq_pkg::VAL_W-1:0] i_b,
    output logic                             o_lt
);
    import apq_pkg::*;

    assign o_lt = (i_a < i_b);

endmodule

### sv/apq_store.sv
// Entry store: one write port and one registered read port.
module apq_store #(
    parameter int DEPTH = 8,
    parameter int AW    = 3
) (
    input  logic                             i_clk,
    input  apq_pkg::t_mem_ctl                i_ctl,
    input  logic [AW-1:0]                    i_rd_addr,
    input  logic [AW-1:0]                    i_wr_addr,
    input  logic signed [apq_pkg::VAL_W-1:0] i_wr_data,
    output logic signed [apq_pkg::VAL_W-1:0] o_rd_data
);
    import apq_pkg::*;

    logic signed [VAL_W-1:0] r_mem [DEPTH];
    logic signed [VAL_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### sv/array_priority_queue_delete_min_top.sv
// Top level of the unsorted-array priority queue with delete-minimum.
//
//  channel | direction | handshake                | word
//  --------+-----------+--------------------------+---------------------------------------
//  in      | input     | i_in_valid / o_in_stall  | func, value
//  out     | output    | o_out_valid / i_out_stall| status, removed_value, occupancy
//
// Sequence: an insert, a full insert or an empty delete goes from acceptance
// straight to the response state. A delete over n entries whose minimum sits
// at slot b scans all n entries, then copies the n - b - 1 entries above b down.
// This pace is set by the single read port of the entry store: the scan
// reads one entry per cycle into the one comparator, and the shift copies
// one entry per cycle.
// Reset (synchronous, active low) empties the queue; entry contents are not
// cleared, slots at or above the count are never read.
// A stalled result word holds in the output register; the block accepts the
// next request meanwhile and holds its own result until the register frees.
module array_priority_queue_delete_min_top #(
    parameter int CAPACITY = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  apq_pkg::t_in_word  i_in_word,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output apq_pkg::t_out_word o_out_word
);
    import apq_pkg::*;

    // Index width for the store, count width able to hold CAPACITY itself.
    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
    localparam logic [CW-1:0] ONE_C = CW'(1);

    // Sequencer and queue state
    t_state                  r_state, n_state;
    logic [CW-1:0]           r_count, n_count;
    logic [CW-1:0]           r_idx, n_idx;       // next slot to read
    logic [CW-1:0]           r_didx, n_didx;     // slot whose data arrives now (scan)
    logic [AW-1:0]           r_widx, n_widx;     // slot to write (shift)
    logic                    r_dv, n_dv;         // read data pending (shift)
    logic signed [VAL_W-1:0] r_best_val, n_best_val;
    logic [AW-1:0]           r_best_idx, n_best_idx;
    t_out_word               r_res, n_res;       // finished result awaiting the output register
    logic                    r_out_valid, n_out_valid;
    t_out_word               r_out_word, n_out_word;

    // Store and compare unit hookup
    t_mem_ctl                mem_ctl;
    logic [AW-1:0]           rd_addr;
    logic [AW-1:0]           wr_addr;
    logic signed [VAL_W-1:0] wr_data;
    logic signed [VAL_W-1:0] rd_data;
    logic                    cmp_lt;

    logic                    in_acc;
    logic                    slot_free;
    logic                    last_scan;
    logic                    take;
    logic [AW-1:0]           scan_best_idx;

    apq_store #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_store (
        .i_clk     (i_clk),
        .i_ctl     (mem_ctl),
        .i_rd_addr (rd_addr),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .o_rd_data (rd_data)
    );

    apq_cmp u_cmp (
        .i_a  (rd_data),
        .i_b  (r_best_val),
        .o_lt (cmp_lt)
    );

    assign o_in_stall  = (r_state != S_IDLE);
    assign in_acc      = i_in_valid && !o_in_stall;
    assign slot_free   = !r_out_valid || !i_out_stall;
    assign last_scan   = (r_didx == (r_count - ONE_C));
    // Strict less-than keeps the earliest slot on a tie.
    assign take          = (r_didx == '0) || cmp_lt;
    assign scan_best_idx = take ? r_didx[AW-1:0] : r_best_idx;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (i_in_word.func == FUNC_INSERT || r_count == '0) begin
                        n_state = S_RESP;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (last_scan) begin
                    n_state = S_SHIFT;
                end
            end
            S_SHIFT: begin
                if (r_idx >= r_count) begin
                    n_state = S_RESP;
                end
            end
            S_RESP: begin
                if (slot_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Datapath and store control
    always_comb begin
        n_count     = r_count;
        n_idx       = r_idx;
        n_didx      = r_didx;
        n_widx      = r_widx;
        n_dv        = r_dv;
        n_best_val  = r_best_val;
        n_best_idx  = r_best_idx;
        n_res       = r_res;
        n_out_word  = r_out_word;
        n_out_valid = r_out_valid;
        mem_ctl     = '0;
        rd_addr     = '0;
        wr_addr     = '0;
        wr_data     = '0;

        // Drop the output word once taken.
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (i_in_word.func == FUNC_INSERT) begin
                        if (r_count < CAP_C) begin
                            // Append at the tail.
                            mem_ctl.wr_en = 1'b1;
                            wr_addr       = r_count[AW-1:0];
                            wr_data       = i_in_word.value;
                            n_count       = r_count + ONE_C;
                            n_res.status        = ST_DONE;
                            n_res.removed_value = '0;
                            n_res.occupancy     = f_occ(32'(r_count + ONE_C));
                        end else begin
                            n_res.status        = ST_FULL;
                            n_res.removed_value = '0;
                            n_res.occupancy     = f_occ(32'(r_count));
                        end
                    end else if (r_count == '0) begin
                        n_res.status        = ST_EMPTY;
                        n_res.removed_value = '0;
                        n_res.occupancy     = f_occ(32'(r_count));
                    end else begin
                        // Start the scan at slot 0.
                        mem_ctl.rd_en = 1'b1;
                        rd_addr       = '0;
                        n_idx         = ONE_C;
                        n_didx        = '0;
                    end
                end
            end
            S_SCAN: begin
                // Fold the arriving entry into the running minimum.
                n_best_idx = scan_best_idx;
                n_best_val = take ? rd_data : r_best_val;
                n_didx     = r_didx + ONE_C;
                if (r_idx < r_count) begin
                    mem_ctl.rd_en = 1'b1;
                    rd_addr       = r_idx[AW-1:0];
                    n_idx         = r_idx + ONE_C;
                end
                if (last_scan) begin
                    // Close the gap: copy slot b+1 onwards down by one.
                    n_idx  = CW'(scan_best_idx) + ONE_C;
                    n_widx = scan_best_idx;
                    n_dv   = 1'b0;
                end
            end
            S_SHIFT: begin
                n_dv = 1'b0;
                if (r_dv) begin
                    mem_ctl.wr_en = 1'b1;
                    wr_addr       = r_widx;
                    wr_data       = rd_data;
                    n_widx        = r_widx + AW'(1);
                end
                if (r_idx < r_count) begin
                    mem_ctl.rd_en = 1'b1;
                    rd_addr       = r_idx[AW-1:0];
                    n_idx         = r_idx + ONE_C;
                    n_dv          = 1'b1;
                end else begin
                    n_count             = r_count - ONE_C;
                    n_res.status        = ST_DONE;
                    n_res.removed_value = r_best_val;
                    n_res.occupancy     = f_occ(32'(r_count - ONE_C));
                end
            end
            S_RESP: begin
                // Advance the result into the output register when it frees.
                if (slot_free) begin
                    n_out_valid = 1'b1;
                    n_out_word  = r_res;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_dv        <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
            r_dv        <= n_dv;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx      <= n_idx;
        r_didx     <= n_didx;
        r_widx     <= n_widx;
        r_best_val <= n_best_val;
        r_best_idx <= n_best_idx;
        r_res      <= n_res;
        r_out_word <= n_out_word;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    // Checks on the sequencer and queue bookkeeping
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CAP_C)
        else $error("entry count above capacity");

    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_in_word.func == FUNC_INSERT && r_count < CAP_C)
        |=> (r_count == $past(r_count) + ONE_C))
        else $error("successful insert did not grow the queue");

    a_shift_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SHIFT && mem_ctl.wr_en) |-> ((CW'(wr_addr) + ONE_C) < r_count))
        else $error("shift wrote outside the occupied slots");

    a_empty_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_word.status == ST_EMPTY)
        |-> (o_out_word.removed_value == '0 && o_out_word.occupancy == '0))
        else $error("empty report carries a value or occupancy");

endmodule

### sim/tb.sv
// Self-checking testbench for the unsorted-array priority queue with delete-minimum.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import apq_pkg::*;

    // Queue depth of the block under test, and the limits the run works to.
    localparam int CAPACITY    = 8;
    localparam int HOLD_CYCLES = 150;               // long receiver hold-off
    localparam int TAIL_CYCLES = 2 * CAPACITY + 23; // worst delete plus margin
    localparam int STUCK_LIMIT = 2000;              // cycles with no word moving
    localparam int MAX_REPORTS = 10;

    // Block ports. Every input starts at a known value.
    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    logic      o_in_stall;
    t_in_word  i_in_word   = '0;
    logic      o_out_valid;
    logic      i_out_stall = 1'b0;
    t_out_word o_out_word;

    // Request words still to be offered, and result words the queue owes us.
    t_in_word  pending_requests[$];
    t_out_word owed_results[$];

    // Our own copy of the queue contents, oldest entry first.
    logic signed [VAL_W-1:0] held_values[$];

    // Hand-over flags between the stimulus, the driver, the receiver and the monitor.
    bit in_taken;       // the offered request word went in at the last rising edge
    bit quiet;          // final part of the run: no idling on either side
    bit hold_req;       // ask the receiver for one long hold-off
    bit hold_served;
    int send_gap;
    int stall_left;
    int hold_left;

    // Run statistics.
    int n_inserts;
    int n_deletes;
    int n_full;
    int n_empty;
    int n_checked;
    int n_in_stalled;
    int mismatches;
    int stuck_cycles;

    array_priority_queue_delete_min_top #(
        .CAPACITY(CAPACITY)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word)
    );

    // 20 ns clock: low half then high half.
    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // Work out the result word one request causes, and update our copy of the queue.
    // A delete takes the smallest value, the earliest one when several tie, and
    // closes the gap so the insertion order of the rest is kept.
    function automatic t_out_word predict_queue_op(input t_in_word req);
        t_out_word res;
        int        best;
        res.status        = ST_DONE;
        res.removed_value = '0;
        if (req.func == FUNC_INSERT) begin
            if (held_values.size() >= CAPACITY) begin
                res.status = ST_FULL;
            end else begin
                held_values.push_back(req.value);
            end
        end else if (held_values.size() == 0) begin
            res.status = ST_EMPTY;
        end else begin
            best = 0;
            for (int i = 1; i < held_values.size(); i++) begin
                // strict less-than keeps the earliest of equal minima
                if (held_values[i] < held_values[best]) begin
                    best = i;
                end
            end
            res.removed_value = held_values[best];
            held_values.delete(best);
        end
        res.occupancy = OCC_W'(held_values.size());
        return res;
    endfunction

    // Fields are shown as status/removed/occupancy.
    task automatic log_mismatch(input string what, input t_out_word want, input t_out_word got);
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
            $display("%0t ns: %s: expected %0d/%0d/%0d, got %0d/%0d/%0d",
                     $realtime, what, want.status, want.removed_value, want.occupancy,
                     got.status, got.removed_value, got.occupancy);
        end
    endtask

    // Request driver: change inputs on the falling edge only. Hold a word until it is
    // taken, then either idle for a burst or offer the next pending word.
    always @(negedge i_clk) begin : drive_requests
        logic     nxt_valid;
        t_in_word nxt_word;
        nxt_valid = i_in_valid;
        nxt_word  = i_in_word;
        if (in_taken || !i_in_valid) begin
            nxt_valid = 1'b0;
            if (send_gap > 0) begin
                send_gap--;
            end else if (!quiet && $urandom_range(0, 9) == 0) begin
                // start an idle burst; send_gap holds how long it lasts
                send_gap = $urandom_range(0, 7);
            end else if (i_rst_n && pending_requests.size() != 0) begin
                nxt_word  = pending_requests.pop_front();
                nxt_valid = 1'b1;
            end
        end
        i_in_valid <= nxt_valid;
        i_in_word  <= nxt_word;
    end

    // Result receiver: stall in random bursts, plus one long hold-off on request
    // so that the queue backs up and stalls its own input.
    always @(negedge i_clk) begin : drive_stall
        logic nxt_stall;
        nxt_stall = 1'b0;
        if (hold_req && !hold_served) begin
            hold_left   = HOLD_CYCLES;
            hold_served = 1'b1;
        end
        if (hold_left > 0) begin
            hold_left--;
            nxt_stall = 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            nxt_stall = 1'b1;
        end else if (!quiet && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 7);
            nxt_stall  = 1'b1;
        end
        i_out_stall <= nxt_stall;
    end

    // Monitor: sample both channels on the rising edge. Predict on every accepted
    // request word, check every accepted result word against the oldest prediction.
    always @(posedge i_clk) begin : watch_channels
        t_out_word want;
        bit        moved;
        in_taken = 1'b0;
        moved    = 1'b0;
        if (i_rst_n) begin
            if (i_in_valid && o_in_stall) begin
                n_in_stalled++;
            end
            if (i_in_valid && !o_in_stall) begin
                in_taken = 1'b1;
                moved    = 1'b1;
                if (i_in_word.func == FUNC_INSERT) begin
                    n_inserts++;
                end else begin
                    n_deletes++;
                end
                owed_results.push_back(predict_queue_op(i_in_word));
            end
            if (o_out_valid && !i_out_stall) begin
                moved = 1'b1;
                n_checked++;
                if (owed_results.size() == 0) begin
                    log_mismatch("result word with no request pending", '0, o_out_word);
                end else begin
                    want = owed_results.pop_front();
                    if (want.status == ST_FULL) begin
                        n_full++;
                    end
                    if (want.status == ST_EMPTY) begin
                        n_empty++;
                    end
                    if (o_out_word.status !== want.status
                            || o_out_word.removed_value !== want.removed_value
                            || o_out_word.occupancy !== want.occupancy) begin
                        log_mismatch("result word mismatch", want, o_out_word);
                    end
                end
            end
            stuck_cycles = moved ? 0 : stuck_cycles + 1;
        end
    end

    // Watchdog: end the run if no word moves on either channel for too long.
    initial begin : watchdog
        while (stuck_cycles < STUCK_LIMIT) begin
            @(negedge i_clk);
        end
        $display("%0t ns: no word moved for %0d cycles, %0d results still owed",
                 $realtime, STUCK_LIMIT, owed_results.size());
        $display("*** FAILED ***");
        $finish;
    end

    task automatic queue_request(input logic func, input logic signed [VAL_W-1:0] value);
        t_in_word req;
        req.func  = func;
        req.value = value;
        pending_requests.push_back(req);
    endtask

    // Random requests in segments of 40. Each segment draws its own insert share,
    // from 25 to 90 percent, so the queue swings between empty and full; a third
    // of values sit near zero for ties, half are full range, the rest extremes.
    task automatic queue_random(input int n);
        int                      insert_pct;
        logic                    func;
        logic signed [VAL_W-1:0] value;
        insert_pct = 50;
        for (int k = 0; k < n; k++) begin
            if (k % 40 == 0) begin
                case ($urandom_range(0, 3))
                    0:       insert_pct = 25;
                    1:       insert_pct = 50;
                    2:       insert_pct = 70;
                    default: insert_pct = 90;
                endcase
            end
            func = ($urandom_range(0, 99) < insert_pct) ? FUNC_INSERT : FUNC_DELETE;
            case ($urandom_range(0, 5))
                0, 1: value = $urandom_range(0, 6) - 3;
                2: begin
                    case ($urandom_range(0, 3))
                        0:       value = 32'sh8000_0000;
                        1:       value = 32'sh7fff_ffff;
                        2:       value = -32'sd1;
                        default: value = '0;
                    endcase
                end
                default: value = $urandom;
            endcase
            queue_request(func, value);
        end
    endtask

    // Wait until every word has gone in and every owed result has come back,
    // then step to a rising edge so new words are queued away from the driver's edge.
    task automatic wait_drained();
        while (pending_requests.size() != 0 || i_in_valid || owed_results.size() != 0) begin
            @(negedge i_clk);
        end
        @(posedge i_clk);
    endtask

    initial begin : stimulus
        // Hold reset low, then release it on a falling edge.
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: delete from empty, fill with the extremes, -1 and a tied
        // minimum, insert when full, then drain past empty again.
        queue_request(FUNC_DELETE, 32'sh5a5a_5a5a);
        queue_request(FUNC_INSERT, -32'sd1);
        queue_request(FUNC_INSERT, 32'sh7fff_ffff);
        queue_request(FUNC_INSERT, 32'sh8000_0000);
        queue_request(FUNC_INSERT, -32'sd1);
        queue_request(FUNC_INSERT, 32'sd0);
        queue_request(FUNC_INSERT, 32'sh8000_0000);
        queue_request(FUNC_INSERT, 32'sd5);
        queue_request(FUNC_INSERT, -32'sd1);
        queue_request(FUNC_INSERT, 32'sd1);       // full: rejected
        queue_request(FUNC_DELETE, 32'shffff_ffff); // earlier of the tied minima
        queue_request(FUNC_INSERT, 32'sh8000_0000);
        queue_request(FUNC_INSERT, 32'sd9);       // full again
        for (int k = 0; k < CAPACITY; k++) begin
            queue_request(FUNC_DELETE, 32'sd0);
        end
        queue_request(FUNC_DELETE, 32'sh7fff_ffff); // empty again
        wait_drained();

        // Random, with idling on both sides.
        queue_random(600);
        wait_drained();

        // Random with one long receiver hold-off while words keep coming.
        queue_random(500);
        hold_req = 1'b1;
        wait_drained();

        // Final part: no idling, back-to-back traffic.
        quiet = 1'b1;
        queue_random(500);
        wait_drained();
        repeat (TAIL_CYCLES) @(negedge i_clk);

        $display("Covered %0d requests: %0d inserts (%0d full), %0d deletes (%0d empty).",
                 n_inserts + n_deletes, n_inserts, n_full, n_deletes, n_empty);
        $display("Checked %0d result words, %0d input stall cycles, %0d mismatches, %0d owed.",
                 n_checked, n_in_stalled, mismatches, owed_results.size());
        if (mismatches == 0 && owed_results.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
